// ===== rtl/dsp_pkg.sv =====
// ----------------------------------------------------------------------------
// dsp_pkg: shared types and constants for the double sphere to pinhole map
// Word format, saturating helpers, unit latencies, codes and the context
// record that travels down the pipeline next to each pixel.
// ----------------------------------------------------------------------------
package dsp_pkg;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 16;
  localparam int WIDE_BITS  = COORD_BITS + FRAC_BITS;
  localparam int XI_BITS    = FRAC_BITS + 3;
  localparam int AL_BITS    = FRAC_BITS + 1;
  localparam int CFG_BITS   = WIDE_BITS;
  localparam int CFG_IDX_BITS = 3;
  localparam int WF         = 32;
  localparam int SH         = WF - FRAC_BITS;
  localparam int OUT_BITS   = 32;
  localparam int RSN_BITS   = 3;

  typedef logic signed [63:0] word_t;

  localparam word_t ONE_W  = 64'sh0000_0001_0000_0000;
  localparam word_t HALF_W = 64'sh0000_0000_8000_0000;
  localparam word_t LIM    = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam word_t EPS_W  = 64'sd4295;

  localparam logic signed [OUT_BITS-1:0] NEG_ONE = -(32'sd1 <<< FRAC_BITS);
  localparam logic signed [OUT_BITS-1:0] OUT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [OUT_BITS-1:0] OUT_MIN = 32'sh8000_0000;

  localparam logic [RSN_BITS-1:0] RSN_OK      = 3'd0;
  localparam logic [RSN_BITS-1:0] RSN_OUTSIDE = 3'd1;
  localparam logic [RSN_BITS-1:0] RSN_MZ_DEN  = 3'd2;
  localparam logic [RSN_BITS-1:0] RSN_TOT_DEN = 3'd3;
  localparam logic [RSN_BITS-1:0] RSN_SHORT   = 3'd4;
  localparam logic [RSN_BITS-1:0] RSN_BEHIND  = 3'd5;

  localparam logic [CFG_IDX_BITS-1:0] CFG_FOCAL_X  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FOCAL_Y  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_X = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_Y = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_XI       = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ALPHA    = 3'd5;

  localparam logic [WIDE_BITS-1:0] FOCAL_RST  = WIDE_BITS'(1834771);
  localparam logic [WIDE_BITS-1:0] CENTER_RST = WIDE_BITS'(134217728);
  localparam logic [XI_BITS-1:0]   XI_RST     = XI_BITS'(32768);
  localparam logic [AL_BITS-1:0]   ALPHA_RST  = AL_BITS'(39322);

  localparam int MUL_LAT     = 3;
  localparam int DIV_STEPS   = 62;
  localparam int DIV_PER     = 2;
  localparam int DIV_STAGES  = (DIV_STEPS + DIV_PER - 1) / DIV_PER;
  localparam int SQRT_STEPS  = 47;
  localparam int SQRT_PER    = 2;
  localparam int SQRT_STAGES = (SQRT_STEPS + SQRT_PER - 1) / SQRT_PER;

  typedef struct packed {
    logic                vld;
    logic [RSN_BITS-1:0] reason;
    word_t du;
    word_t dv;
    word_t mx;
    word_t my;
    word_t rt;
    word_t r2;
    word_t aa;
    word_t omxx;
    word_t rad1;
    word_t mznum;
    word_t wr2;
    word_t den;
    word_t mz;
    word_t mzxi;
    word_t rad2;
    word_t dtot;
    word_t num;
    word_t scale;
    word_t xs;
    word_t ys;
    word_t zc;
    word_t norm2;
    word_t k;
  } ctx_t;

  function automatic word_t clampw(input logic signed [64:0] a);
    if (a > 65'(LIM)) return LIM;
    if (a < -65'(LIM)) return -LIM;
    return a[63:0];
  endfunction

  function automatic word_t sadd(input word_t a, input word_t b);
    return clampw(65'(a) + 65'(b));
  endfunction

  function automatic word_t ssub(input word_t a, input word_t b);
    return clampw(65'(a) - 65'(b));
  endfunction

  function automatic logic [61:0] mag(input word_t a);
    word_t n;
    n = -a;
    return a[63] ? n[61:0] : a[61:0];
  endfunction

  function automatic logic tiny(input word_t a);
    return (a < EPS_W) && (a > -EPS_W);
  endfunction

endpackage

// ===== rtl/double_sphere_to_pinhole_map.sv =====
// ----------------------------------------------------------------------------
// double_sphere_to_pinhole_map: pinhole source coordinate for each pixel
// Unprojects a pixel through the double sphere model and reprojects the ray
// through a pinhole with the same intrinsics.
// ----------------------------------------------------------------------------
// One pixel is taken every clock while in_stall is low; the pipeline depth is
// set by the chain of four pipelined dividers (two quotient bits per stage),
// three pipelined square roots and seven three-stage multiplier steps, plus
// input and output registers. The whole pipeline holds while a result waits
// at the output with stall high. Configuration writes take effect at once
// and belong to idle periods.
module double_sphere_to_pinhole_map (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [dsp_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [dsp_pkg::CFG_BITS-1:0]         cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [dsp_pkg::COORD_BITS-1:0]       pixel_col,
  input  logic [dsp_pkg::COORD_BITS-1:0]       pixel_row,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [dsp_pkg::OUT_BITS-1:0]  source_col,
  output logic signed [dsp_pkg::OUT_BITS-1:0]  source_row,
  output logic                                 map_valid,
  output logic [dsp_pkg::RSN_BITS-1:0]         fail_reason
);

  logic [dsp_pkg::WIDE_BITS-1:0] focal_x;
  logic [dsp_pkg::WIDE_BITS-1:0] focal_y;
  logic [dsp_pkg::WIDE_BITS-1:0] center_x;
  logic [dsp_pkg::WIDE_BITS-1:0] center_y;
  logic [dsp_pkg::XI_BITS-1:0]   sphere_offset;
  logic [dsp_pkg::AL_BITS-1:0]   blend_factor;

  logic           en;
  dsp_pkg::word_t fx;
  dsp_pkg::word_t fy;
  dsp_pkg::word_t cxw;
  dsp_pkg::word_t cyw;
  dsp_pkg::word_t xi;
  dsp_pkg::word_t al;
  dsp_pkg::word_t tw;
  dsp_pkg::word_t oma;

  logic signed [dsp_pkg::WIDE_BITS:0] du_n;
  logic signed [dsp_pkg::WIDE_BITS:0] dv_n;
  dsp_pkg::ctx_t  c0;
  dsp_pkg::ctx_t  c0_next;
  dsp_pkg::ctx_t  k1, k2, k3, k4, k5, k6, k7, k8, k9, k10, k11, k12, k13, k14;
  dsp_pkg::ctx_t  e1, e2, e3, e4, e5, e6, e7, e8, e9, e10, e11, e12, e13;
  dsp_pkg::word_t mx_q, my_q, rt_q;
  dsp_pkg::word_t mxx, myy, aa_q, ii_q;
  dsp_pkg::word_t tr2, a2r2, wr2_q;
  dsp_pkg::word_t sq1, alsq, mz_q, mzmz, mzxi_q, srad, scale_q;
  dsp_pkg::word_t smx, smy, smz, xsq, ysq, zsq, snorm, k_q, duk, dvk;
  dsp_pkg::word_t ocol, orow;

  function automatic logic signed [dsp_pkg::OUT_BITS-1:0] to_out(input dsp_pkg::word_t v);
    dsp_pkg::word_t              w;
    logic signed [63-dsp_pkg::SH:0] qv;
    w  = v + (64'sd1 <<< (dsp_pkg::SH - 1));
    qv = w[63:dsp_pkg::SH];
    if (qv > (64-dsp_pkg::SH)'(dsp_pkg::OUT_MAX)) return dsp_pkg::OUT_MAX;
    if (qv < (64-dsp_pkg::SH)'(dsp_pkg::OUT_MIN)) return dsp_pkg::OUT_MIN;
    return qv[dsp_pkg::OUT_BITS-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x       <= dsp_pkg::FOCAL_RST;
      focal_y       <= dsp_pkg::FOCAL_RST;
      center_x      <= dsp_pkg::CENTER_RST;
      center_y      <= dsp_pkg::CENTER_RST;
      sphere_offset <= dsp_pkg::XI_RST;
      blend_factor  <= dsp_pkg::ALPHA_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        dsp_pkg::CFG_FOCAL_X:  focal_x       <= cfg_data[dsp_pkg::WIDE_BITS-1:0];
        dsp_pkg::CFG_FOCAL_Y:  focal_y       <= cfg_data[dsp_pkg::WIDE_BITS-1:0];
        dsp_pkg::CFG_CENTER_X: center_x      <= cfg_data[dsp_pkg::WIDE_BITS-1:0];
        dsp_pkg::CFG_CENTER_Y: center_y      <= cfg_data[dsp_pkg::WIDE_BITS-1:0];
        dsp_pkg::CFG_XI:       sphere_offset <= cfg_data[dsp_pkg::XI_BITS-1:0];
        dsp_pkg::CFG_ALPHA:    blend_factor  <= cfg_data[dsp_pkg::AL_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    fx  = dsp_pkg::word_t'({1'b0, (focal_x == '0) ? dsp_pkg::WIDE_BITS'(1) : focal_x})
          <<< dsp_pkg::SH;
    fy  = dsp_pkg::word_t'({1'b0, (focal_y == '0) ? dsp_pkg::WIDE_BITS'(1) : focal_y})
          <<< dsp_pkg::SH;
    cxw = dsp_pkg::word_t'({1'b0, center_x}) <<< dsp_pkg::SH;
    cyw = dsp_pkg::word_t'({1'b0, center_y}) <<< dsp_pkg::SH;
    xi  = dsp_pkg::word_t'($signed(sphere_offset)) <<< dsp_pkg::SH;
    al  = dsp_pkg::word_t'({1'b0, blend_factor}) <<< dsp_pkg::SH;
    tw  = dsp_pkg::ssub(dsp_pkg::sadd(al, al), dsp_pkg::ONE_W);
    oma = dsp_pkg::ssub(dsp_pkg::ONE_W, al);
    du_n = $signed({1'b0, pixel_col, dsp_pkg::FRAC_BITS'(0)}) - $signed({1'b0, center_x});
    dv_n = $signed({1'b0, pixel_row, dsp_pkg::FRAC_BITS'(0)}) - $signed({1'b0, center_y});
  end

  always_comb begin
    c0_next        = '0;
    c0_next.vld    = in_valid;
    c0_next.reason = dsp_pkg::RSN_OK;
    c0_next.du     = dsp_pkg::word_t'(du_n) <<< dsp_pkg::SH;
    c0_next.dv     = dsp_pkg::word_t'(dv_n) <<< dsp_pkg::SH;
  end

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      c0.vld <= 1'b0;
    end else if (en) begin
      c0 <= c0_next;
    end
  end

  dsp_div u_div_mx (.clk, .rst, .en, .a(c0.du), .b(fx), .ci(c0), .q(mx_q), .co(k1));
  dsp_div u_div_my (.clk, .rst, .en, .a(c0.dv), .b(fy), .ci(c0), .q(my_q), .co());
  dsp_div u_div_rt (.clk, .rst, .en, .a(dsp_pkg::ONE_W), .b(tw), .ci(c0), .q(rt_q), .co());

  always_comb begin
    e1    = k1;
    e1.mx = mx_q;
    e1.my = my_q;
    e1.rt = rt_q;
  end

  dsp_mul u_mul_xx (.clk, .rst, .en, .a(e1.mx), .b(e1.mx), .ci(e1), .p(mxx), .co(k2));
  dsp_mul u_mul_yy (.clk, .rst, .en, .a(e1.my), .b(e1.my), .ci(e1), .p(myy), .co());
  dsp_mul u_mul_aa (.clk, .rst, .en, .a(al), .b(al), .ci(e1), .p(aa_q), .co());
  dsp_mul u_mul_ii (.clk, .rst, .en, .a(xi), .b(xi), .ci(e1), .p(ii_q), .co());

  always_comb begin
    e2      = k2;
    e2.r2   = dsp_pkg::sadd(mxx, myy);
    e2.aa   = aa_q;
    e2.omxx = dsp_pkg::ssub(dsp_pkg::ONE_W, ii_q);
    if ((al > dsp_pkg::HALF_W) && (e2.r2 > k2.rt)) begin
      e2.reason = dsp_pkg::RSN_OUTSIDE;
    end
  end

  dsp_mul u_mul_tr (.clk, .rst, .en, .a(tw), .b(e2.r2), .ci(e2), .p(tr2), .co(k3));
  dsp_mul u_mul_ar (.clk, .rst, .en, .a(e2.aa), .b(e2.r2), .ci(e2), .p(a2r2), .co());
  dsp_mul u_mul_wr (.clk, .rst, .en, .a(e2.omxx), .b(e2.r2), .ci(e2), .p(wr2_q), .co());

  always_comb begin
    e3       = k3;
    e3.rad1  = dsp_pkg::ssub(dsp_pkg::ONE_W, tr2);
    e3.mznum = dsp_pkg::ssub(dsp_pkg::ONE_W, a2r2);
    e3.wr2   = wr2_q;
  end

  dsp_sqrt u_sqrt_1 (.clk, .rst, .en, .x(e3.rad1), .ci(e3), .r(sq1), .co(k4));

  assign e4 = k4;

  dsp_mul u_mul_as (.clk, .rst, .en, .a(al), .b(sq1), .ci(e4), .p(alsq), .co(k5));

  always_comb begin
    e5     = k5;
    e5.den = dsp_pkg::sadd(alsq, oma);
    if ((e5.reason == dsp_pkg::RSN_OK) && dsp_pkg::tiny(e5.den)) begin
      e5.reason = dsp_pkg::RSN_MZ_DEN;
    end
  end

  dsp_div u_div_mz (.clk, .rst, .en, .a(e5.mznum), .b(e5.den), .ci(e5), .q(mz_q), .co(k6));

  always_comb begin
    e6    = k6;
    e6.mz = mz_q;
  end

  dsp_mul u_mul_zz (.clk, .rst, .en, .a(e6.mz), .b(e6.mz), .ci(e6), .p(mzmz), .co(k7));
  dsp_mul u_mul_zx (.clk, .rst, .en, .a(e6.mz), .b(xi), .ci(e6), .p(mzxi_q), .co());

  always_comb begin
    e7      = k7;
    e7.rad2 = dsp_pkg::sadd(mzmz, k7.wr2);
    e7.dtot = dsp_pkg::sadd(mzmz, k7.r2);
    e7.mzxi = mzxi_q;
    if ((e7.reason == dsp_pkg::RSN_OK) && dsp_pkg::tiny(e7.dtot)) begin
      e7.reason = dsp_pkg::RSN_TOT_DEN;
    end
  end

  dsp_sqrt u_sqrt_2 (.clk, .rst, .en, .x(e7.rad2), .ci(e7), .r(srad), .co(k8));

  always_comb begin
    e8     = k8;
    e8.num = dsp_pkg::sadd(k8.mzxi, srad);
  end

  dsp_div u_div_sc (.clk, .rst, .en, .a(e8.num), .b(e8.dtot), .ci(e8), .q(scale_q), .co(k9));

  always_comb begin
    e9       = k9;
    e9.scale = scale_q;
  end

  dsp_mul u_mul_sx (.clk, .rst, .en, .a(e9.scale), .b(e9.mx), .ci(e9), .p(smx), .co(k10));
  dsp_mul u_mul_sy (.clk, .rst, .en, .a(e9.scale), .b(e9.my), .ci(e9), .p(smy), .co());
  dsp_mul u_mul_sz (.clk, .rst, .en, .a(e9.scale), .b(e9.mz), .ci(e9), .p(smz), .co());

  always_comb begin
    e10    = k10;
    e10.xs = smx;
    e10.ys = smy;
    e10.zc = dsp_pkg::ssub(smz, xi);
  end

  dsp_mul u_mul_x2 (.clk, .rst, .en, .a(e10.xs), .b(e10.xs), .ci(e10), .p(xsq), .co(k11));
  dsp_mul u_mul_y2 (.clk, .rst, .en, .a(e10.ys), .b(e10.ys), .ci(e10), .p(ysq), .co());
  dsp_mul u_mul_z2 (.clk, .rst, .en, .a(e10.zc), .b(e10.zc), .ci(e10), .p(zsq), .co());

  always_comb begin
    e11       = k11;
    e11.norm2 = dsp_pkg::sadd(dsp_pkg::sadd(xsq, ysq), zsq);
  end

  dsp_sqrt u_sqrt_3 (.clk, .rst, .en, .x(e11.norm2), .ci(e11), .r(snorm), .co(k12));

  always_comb begin
    e12 = k12;
    if (e12.reason == dsp_pkg::RSN_OK) begin
      if (snorm < dsp_pkg::EPS_W) begin
        e12.reason = dsp_pkg::RSN_SHORT;
      end else if (e12.zc <= 0) begin
        e12.reason = dsp_pkg::RSN_BEHIND;
      end
    end
  end

  dsp_div u_div_k (.clk, .rst, .en, .a(e12.scale), .b(e12.zc), .ci(e12), .q(k_q), .co(k13));

  always_comb begin
    e13   = k13;
    e13.k = k_q;
  end

  dsp_mul u_mul_uk (.clk, .rst, .en, .a(e13.du), .b(e13.k), .ci(e13), .p(duk), .co(k14));
  dsp_mul u_mul_vk (.clk, .rst, .en, .a(e13.dv), .b(e13.k), .ci(e13), .p(dvk), .co());

  assign ocol = dsp_pkg::sadd(cxw, duk);
  assign orow = dsp_pkg::sadd(cyw, dvk);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid   <= k14.vld;
      fail_reason <= k14.reason;
      if (k14.reason == dsp_pkg::RSN_OK) begin
        source_col <= to_out(ocol);
        source_row <= to_out(orow);
        map_valid  <= 1'b1;
      end else begin
        source_col <= dsp_pkg::NEG_ONE;
        source_row <= dsp_pkg::NEG_ONE;
        map_valid  <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_ok_reason: assert property (@(posedge clk) disable iff (rst)
    out_valid && map_valid |-> fail_reason == dsp_pkg::RSN_OK)
    else $error("valid mapping carries a fail reason");

  a_fail_coords: assert property (@(posedge clk) disable iff (rst)
    out_valid && !map_valid |-> fail_reason != dsp_pkg::RSN_OK &&
      source_col == dsp_pkg::NEG_ONE && source_row == dsp_pkg::NEG_ONE)
    else $error("invalid mapping without reason or -1.0 coordinates");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output beat is free");
`endif

endmodule

// ===== rtl/dsp_mul.sv =====
// ----------------------------------------------------------------------------
// dsp_mul: pipelined Q30.32 multiplier
// Magnitudes, four partial products of 32/30-bit halves, then round half
// away from zero and saturate. Three stages; the context rides along.
// ----------------------------------------------------------------------------
module dsp_mul (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  dsp_pkg::word_t a,
  input  dsp_pkg::word_t b,
  input  dsp_pkg::ctx_t  ci,
  output dsp_pkg::word_t p,
  output dsp_pkg::ctx_t  co
);

  dsp_pkg::ctx_t  c0;
  dsp_pkg::ctx_t  c1;
  logic           neg0;
  logic           neg1;
  logic [61:0]    ma;
  logic [61:0]    mb;
  logic [63:0]    p00;
  logic [61:0]    p01;
  logic [61:0]    p10;
  logic [59:0]    p11;
  logic [125:0]   full;
  logic [93:0]    rnd;
  dsp_pkg::word_t mr;

  always_comb begin
    full = 126'(p00) + (126'(p01) << 32) + (126'(p10) << 32) + (126'(p11) << 64)
         + 126'(dsp_pkg::HALF_W);
    rnd  = full[125:32];
    mr   = (|rnd[93:62]) ? dsp_pkg::LIM : dsp_pkg::word_t'({2'b00, rnd[61:0]});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c0.vld <= 1'b0;
      c1.vld <= 1'b0;
      co.vld <= 1'b0;
    end else if (en) begin
      c0   <= ci;
      neg0 <= a[63] ^ b[63];
      ma   <= dsp_pkg::mag(a);
      mb   <= dsp_pkg::mag(b);
      c1   <= c0;
      neg1 <= neg0;
      p00  <= ma[31:0] * mb[31:0];
      p01  <= ma[31:0] * mb[61:32];
      p10  <= ma[61:32] * mb[31:0];
      p11  <= ma[61:32] * mb[61:32];
      co   <= c1;
      p    <= neg1 ? -mr : mr;
    end
  end

endmodule

// ===== rtl/dsp_div.sv =====
// ----------------------------------------------------------------------------
// dsp_div: pipelined Q30.32 divider
// Restoring division of a 94-bit dividend, two quotient bits per stage,
// rounded to nearest and saturated. Quotients of 2^62 or more are caught
// up front.
// ----------------------------------------------------------------------------
module dsp_div (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  dsp_pkg::word_t a,
  input  dsp_pkg::word_t b,
  input  dsp_pkg::ctx_t  ci,
  output dsp_pkg::word_t q,
  output dsp_pkg::ctx_t  co
);

  typedef struct packed {
    logic          neg;
    logic          dz;
    logic          az;
    logic          big;
    logic [61:0]   ub;
    logic [63:0]   rem;
    logic [61:0]   nb;
    logic [61:0]   qt;
    dsp_pkg::ctx_t c;
  } div_st_t;

  div_st_t        st [dsp_pkg::DIV_STAGES+1];
  logic [61:0]    ua;
  logic [61:0]    ub;
  logic [62:0]    qr;
  dsp_pkg::word_t res;
  div_st_t        last;

  assign ua = dsp_pkg::mag(a);
  assign ub = dsp_pkg::mag(b);

  always_ff @(posedge clk) begin
    if (rst) begin
      st[0].c.vld <= 1'b0;
    end else if (en) begin
      st[0].neg <= a[63] ^ b[63];
      st[0].dz  <= (ub == '0);
      st[0].az  <= (ua == '0);
      st[0].big <= (62'(ua[61:30]) >= ub);
      st[0].ub  <= ub;
      st[0].rem <= 64'(ua[61:30]);
      st[0].nb  <= {ua[29:0], 32'd0};
      st[0].qt  <= '0;
      st[0].c   <= ci;
    end
  end

  for (genvar s = 0; s < dsp_pkg::DIV_STAGES; s++) begin : g_stage
    div_st_t nx;
    always_comb begin
      logic [63:0] r2;
      nx = st[s];
      r2 = '0;
      for (int j = 0; j < dsp_pkg::DIV_PER; j++) begin
        r2    = {nx.rem[62:0], nx.nb[61]};
        nx.nb = {nx.nb[60:0], 1'b0};
        if (r2 >= {2'b00, nx.ub}) begin
          nx.rem = r2 - {2'b00, nx.ub};
          nx.qt  = {nx.qt[60:0], 1'b1};
        end else begin
          nx.rem = r2;
          nx.qt  = {nx.qt[60:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        st[s+1].c.vld <= 1'b0;
      end else if (en) begin
        st[s+1] <= nx;
      end
    end
  end

  always_comb begin
    last = st[dsp_pkg::DIV_STAGES];
    qr   = {1'b0, last.qt} + 63'({last.rem, 1'b0} >= {3'b000, last.ub});
    if (last.dz) begin
      res = last.az ? '0 : dsp_pkg::LIM;
    end else if (last.big || (64'(qr) > 64'(dsp_pkg::LIM))) begin
      res = dsp_pkg::LIM;
    end else begin
      res = dsp_pkg::word_t'(qr);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      co.vld <= 1'b0;
    end else if (en) begin
      co <= last.c;
      q  <= last.neg ? -res : res;
    end
  end

endmodule

// ===== rtl/dsp_sqrt.sv =====
// ----------------------------------------------------------------------------
// dsp_sqrt: pipelined Q30.32 square root
// Digit-by-digit floor root of x << 32, two root bits per stage; zero for
// a non-positive radicand.
// ----------------------------------------------------------------------------
module dsp_sqrt (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  dsp_pkg::word_t x,
  input  dsp_pkg::ctx_t  ci,
  output dsp_pkg::word_t r,
  output dsp_pkg::ctx_t  co
);

  typedef struct packed {
    logic [93:0]   n;
    logic [50:0]   rem;
    logic [46:0]   root;
    dsp_pkg::ctx_t c;
  } sq_st_t;

  sq_st_t st [dsp_pkg::SQRT_STAGES+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      st[0].c.vld <= 1'b0;
    end else if (en) begin
      st[0].n    <= (x > 0) ? {x[61:0], 32'd0} : '0;
      st[0].rem  <= '0;
      st[0].root <= '0;
      st[0].c    <= ci;
    end
  end

  for (genvar s = 0; s < dsp_pkg::SQRT_STAGES; s++) begin : g_stage
    sq_st_t nx;
    always_comb begin
      logic [50:0] rr;
      logic [50:0] trial;
      nx    = st[s];
      rr    = '0;
      trial = '0;
      for (int j = 0; j < dsp_pkg::SQRT_PER; j++) begin
        if (s * dsp_pkg::SQRT_PER + j < dsp_pkg::SQRT_STEPS) begin
          rr    = {nx.rem[48:0], nx.n[93:92]};
          nx.n  = {nx.n[91:0], 2'b00};
          trial = {2'b00, nx.root, 2'b01};
          if (rr >= trial) begin
            nx.rem  = rr - trial;
            nx.root = {nx.root[45:0], 1'b1};
          end else begin
            nx.rem  = rr;
            nx.root = {nx.root[45:0], 1'b0};
          end
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        st[s+1].c.vld <= 1'b0;
      end else if (en) begin
        st[s+1] <= nx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      co.vld <= 1'b0;
    end else if (en) begin
      co <= st[dsp_pkg::SQRT_STAGES].c;
      r  <= dsp_pkg::word_t'({17'd0, st[dsp_pkg::SQRT_STAGES].root});
    end
  end

endmodule
